// ----- hw/rtl/max_abs_frame_decimator_assert.svh -----
// Assertion macros used by the checker of the frame decimator.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef MAX_ABS_FRAME_DECIMATOR_ASSERT_SVH
`define MAX_ABS_FRAME_DECIMATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MAFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MAFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mafd_pkg.sv -----
`timescale 1ns / 1ps

package mafd_pkg;

  // Default datapath widths.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LEN_BITS_DEF    = 16;

  // Repeats per input sample beyond this count are dropped.
  localparam int MAX_RESULTS = 64;
  localparam int REP_BITS    = $clog2(MAX_RESULTS + 1);

  // Register values after reset.
  localparam int IN_LEN_RESET  = 1024;
  localparam int OUT_LEN_RESET = 256;

  // Configuration register map.
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_LEN  = 1'b0,
    REG_OUT_LEN = 1'b1
  } cfg_reg_e;

  // Per-cycle control from the resampling core to the top level.
  typedef struct packed {
    logic step;       // the held sample is finished and leaves the input stage
    logic emit;       // a result beat is loaded into the output register
    logic last;       // final result caused by the held sample
    logic frame_end;  // final result of the frame
  } mafd_ctl_t;

endpackage

// ----- hw/rtl/mafd_if.sv -----
`timescale 1ns / 1ps

// Input channel: one sample per beat.
interface mafd_in_if import mafd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Output channel: one chosen value per beat with its markers.
interface mafd_out_if import mafd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          last;
  logic                          frame_end;

  modport source (output valid, output value, output last, output frame_end, input ready);
  modport sink   (input valid, input value, input last, input frame_end, output ready);
endinterface

// ----- hw/rtl/mafd_core.sv -----
`timescale 1ns / 1ps

module mafd_core import mafd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LEN_BITS    = LEN_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [LEN_BITS-1:0]           cfg_data_i,
  input  logic                          stg_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] stg_sample_i,
  input  logic                          out_free_i,
  output mafd_ctl_t                     ctl_o,
  output logic signed [SAMPLE_BITS-1:0] value_o
);

  // The boundary accumulator needs two bits over the length width.
  localparam int AccBits = LEN_BITS + 2;

  logic [LEN_BITS-1:0]           in_len_q, in_len_d;
  logic [LEN_BITS-1:0]           out_len_q, out_len_d;
  logic [LEN_BITS-1:0]           sidx_q, sidx_d;
  logic signed [AccBits-1:0]     acc_q, acc_d;
  logic                          fresh_q, fresh_d;
  logic signed [SAMPLE_BITS-1:0] best_q, best_d;
  logic [SAMPLE_BITS-1:0]        bmag_q, bmag_d;
  logic                          gopen_q, gopen_d;
  logic [REP_BITS-1:0]           rep_q, rep_d;

  logic [LEN_BITS-1:0]           n_len;
  logic signed [AccBits-1:0]     n_x, out_x, acc_init, acc;
  logic signed [AccBits-1:0]     acc_dn, acc_dn_emit, acc_up;
  logic                          no_out, down, up, is_final;
  logic [SAMPLE_BITS-1:0]        raw, mag, cand_mag;
  logic signed [SAMPLE_BITS-1:0] cand;
  logic                          take_new, dn_emit, up_done, up_fire, ovf;

  // Frame geometry; a zero input length counts as one.
  assign n_len    = (in_len_q == '0) ? LEN_BITS'(1) : in_len_q;
  assign n_x      = signed'({2'b00, n_len});
  assign out_x    = signed'({2'b00, out_len_q});
  assign no_out   = (out_len_q == '0);
  assign down     = !no_out && (n_len > out_len_q);
  assign up       = !no_out && !down;
  assign is_final = (sidx_q == (n_len - LEN_BITS'(1)));

  // Accumulator at frame start. Decimation tracks (j+1)*in - (i+2)*out and
  // closes a group when it goes negative; repetition tracks (i+1)*out - j*in
  // and repeats while it stays positive.
  assign acc_init = down ? (n_x - (out_x <<< 1)) : out_x;
  assign acc      = fresh_q ? acc_init : acc_q;

  // Magnitude of the held sample; the most negative code maps to its full size.
  assign raw = stg_sample_i;
  assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

  // Running maximum; the earlier sample wins a tie.
  assign take_new = !gopen_q || (mag > bmag_q);
  assign cand     = take_new ? stg_sample_i : best_q;
  assign cand_mag = take_new ? mag : bmag_q;

  assign acc_dn      = acc - out_x;
  assign acc_dn_emit = acc_dn + n_x;
  assign dn_emit     = acc[AccBits-1];

  assign acc_up  = acc - n_x;
  assign up_done = acc_up[AccBits-1] || (acc_up == '0);
  assign ovf     = (rep_q == REP_BITS'(MAX_RESULTS));
  assign up_fire = stg_valid_i && up && (ovf || out_free_i);

  // Control toward the stage and output registers.
  always_comb begin
    ctl_o   = '0;
    value_o = cand;
    if (stg_valid_i) begin
      if (down) begin
        ctl_o.step      = !dn_emit || out_free_i;
        ctl_o.emit      = dn_emit && out_free_i;
        ctl_o.last      = 1'b1;
        ctl_o.frame_end = is_final;
      end else if (up) begin
        value_o         = stg_sample_i;
        ctl_o.emit      = !ovf && out_free_i;
        ctl_o.step      = up_fire && up_done;
        ctl_o.last      = up_done || (rep_q == REP_BITS'(MAX_RESULTS - 1));
        ctl_o.frame_end = ctl_o.last && is_final;
      end else begin
        ctl_o.step = 1'b1;
      end
    end
  end

  // Next state of the frame counters and the group candidate.
  always_comb begin
    in_len_d  = in_len_q;
    out_len_d = out_len_q;
    sidx_d    = sidx_q;
    acc_d     = acc_q;
    fresh_d   = fresh_q;
    best_d    = best_q;
    bmag_d    = bmag_q;
    gopen_d   = gopen_q;
    rep_d     = rep_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IN_LEN:  in_len_d  = cfg_data_i;
        REG_OUT_LEN: out_len_d = cfg_data_i;
        default: ;
      endcase
      fresh_d = 1'b1;
      sidx_d  = '0;
      gopen_d = 1'b0;
      rep_d   = '0;
    end else if (stg_valid_i) begin
      if (down && ctl_o.step) begin
        fresh_d = 1'b0;
        if (dn_emit) begin
          gopen_d = 1'b0;
          acc_d   = acc_dn_emit;
        end else begin
          best_d  = cand;
          bmag_d  = cand_mag;
          gopen_d = 1'b1;
          acc_d   = acc_dn;
        end
      end
      if (up_fire) begin
        fresh_d = 1'b0;
        if (up_done) begin
          acc_d = acc_up + out_x;
          rep_d = '0;
        end else begin
          acc_d = acc_up;
          rep_d = ovf ? rep_q : (rep_q + 1'b1);
        end
      end
      if (ctl_o.step) begin
        if (is_final) begin
          sidx_d  = '0;
          fresh_d = 1'b1;
          gopen_d = 1'b0;
          rep_d   = '0;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q  <= LEN_BITS'(IN_LEN_RESET);
      out_len_q <= LEN_BITS'(OUT_LEN_RESET);
      sidx_q    <= '0;
      fresh_q   <= 1'b1;
      gopen_q   <= 1'b0;
      rep_q     <= '0;
    end else begin
      in_len_q  <= in_len_d;
      out_len_q <= out_len_d;
      sidx_q    <= sidx_d;
      fresh_q   <= fresh_d;
      gopen_q   <= gopen_d;
      rep_q     <= rep_d;
    end
  end

  // Datapath state; only read while qualified by fresh_q or gopen_q.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    best_q <= best_d;
    bmag_q <= bmag_d;
  end

endmodule

// ----- hw/rtl/max_abs_frame_decimator.sv -----
`timescale 1ns / 1ps
// Path: a sample waits in the input stage register, its results in the output register.
// Throughput: one sample per cycle while decimating or copying, unless the output stalls;
// when repeating, one result beat per cycle unless the output stalls; a sample holds the
// input stage until its last repeat; repeats beyond the cap of 64 pass as silent steps.
// Reset: asynchronous, active low; lengths return to 1024 in and 256 out, frame restarts.
module max_abs_frame_decimator import mafd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LEN_BITS    = LEN_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [LEN_BITS-1:0]     cfg_data_i,
  mafd_in_if.sink                 sample_i,
  mafd_out_if.source              result_o
);

  logic                          stv_q, stv_d;
  logic signed [SAMPLE_BITS-1:0] stg_q;
  logic                          ov_q, ov_d;
  logic signed [SAMPLE_BITS-1:0] oval_q;
  logic                          olast_q, ofe_q;
  logic                          out_free;
  logic                          in_fire;
  mafd_ctl_t                     ctl;
  logic signed [SAMPLE_BITS-1:0] core_value;

  // The output register can take a beat when empty or being drained.
  assign out_free       = !ov_q || result_o.ready;
  assign sample_i.ready = !stv_q || ctl.step;
  assign in_fire        = sample_i.valid && sample_i.ready;

  mafd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_BITS    (LEN_BITS)
  ) u_mafd_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .stg_valid_i  (stv_q),
    .stg_sample_i (stg_q),
    .out_free_i   (out_free),
    .ctl_o        (ctl),
    .value_o      (core_value)
  );

  // Occupancy of the input stage and the output register.
  always_comb begin
    stv_d = stv_q;
    if (in_fire) begin
      stv_d = 1'b1;
    end else if (ctl.step) begin
      stv_d = 1'b0;
    end
    ov_d = ov_q;
    if (ctl.emit) begin
      ov_d = 1'b1;
    end else if (result_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stv_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      stv_q <= stv_d;
      ov_q  <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_q <= sample_i.sample;
    end
    if (ctl.emit) begin
      oval_q  <= core_value;
      olast_q <= ctl.last;
      ofe_q   <= ctl.frame_end;
    end
  end

  assign result_o.valid     = ov_q;
  assign result_o.value     = oval_q;
  assign result_o.last      = olast_q;
  assign result_o.frame_end = ofe_q;

endmodule

// ----- hw/rtl/mafd_checker.sv -----
`timescale 1ns / 1ps
`include "max_abs_frame_decimator_assert.svh"

module mafd_checker import mafd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [SAMPLE_BITS-1:0] out_value_i,
  input logic                          out_last_i,
  input logic                          out_frame_end_i
);

  // The end of a frame always closes the burst of the sample that caused it.
  `MAFD_ASSERT_IMP(a_fe_last, out_valid_i && out_frame_end_i, out_last_i, "frame_end without last")

  // Coming out of reset the block is empty and takes input.
  `MAFD_ASSERT_IMP(a_reset_empty, !$past(rst_ni), !out_valid_i && in_ready_i, "not empty after reset")

  // A stalled result beat stays offered.
  `MAFD_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped")

  // A stalled result beat keeps its payload.
  `MAFD_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i,
    $stable(out_value_i) && $stable(out_last_i) && $stable(out_frame_end_i), "payload changed")

endmodule

bind max_abs_frame_decimator mafd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mafd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (sample_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_value_i     (result_o.value),
  .out_last_i      (result_o.last),
  .out_frame_end_i (result_o.frame_end)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mafd_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int LW = LEN_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    last;
    logic    frame_end;
  } result_t;

  typedef struct {
    sample_t sample;
    bit      drain;
  } stim_t;

  localparam sample_t SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam sample_t SMP_MAX = {1'b0, {(SW-1){1'b1}}};

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [LW-1:0] cfg_data_i;

  mafd_in_if  #(.SAMPLE_BITS(SW)) sample_if ();
  mafd_out_if #(.SAMPLE_BITS(SW)) result_if ();

  max_abs_frame_decimator #(
    .SAMPLE_BITS(SW),
    .LEN_BITS   (LW)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sample_i  (sample_if),
    .result_o  (result_if)
  );

  always #4 clk_i = ~clk_i;

  // Shadow of the frame resampler: lengths, frame counters and the running pick.
  logic [LW-1:0] len_in;
  logic [LW-1:0] len_out;
  logic [LW-1:0] smp_idx;
  logic [LW-1:0] out_idx;
  logic [LW-1:0] grp_end;
  sample_t       best_val;
  logic [SW:0]   best_mag;
  logic          holding;
  longint unsigned drop_tail;

  result_t expected_beats[$];
  stim_t   sample_backlog[$];
  int      beats_queued;
  int      beats_taken;
  int      mismatches;
  bit      src_gaps;
  bit      sink_stalls;
  int      src_idle;
  int      sink_idle;
  result_t head;
  int unsigned cycle_cnt;

  // A zero input length behaves as a frame of one sample.
  function automatic longint unsigned frame_len();
    return (len_in == 0) ? 64'd1 : longint'(len_in);
  endfunction

  function automatic logic [LW-1:0] next_group_end();
    longint unsigned n;
    n = frame_len();
    if (len_out == 0) return LW'(n);
    return LW'(((longint'(out_idx) + 1) * n) / longint'(len_out));
  endfunction

  function automatic void restart_frame();
    smp_idx  = '0;
    out_idx  = '0;
    best_val = '0;
    best_mag = '0;
    holding  = 1'b0;
    grp_end  = next_group_end();
  endfunction

  // Works out the result beats that one accepted sample causes.
  function automatic void resample_sample(sample_t s);
    longint unsigned n;
    longint unsigned mag;
    longint unsigned upto;
    longint unsigned total;
    int              cnt;
    result_t         r;
    n   = frame_len();
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    drop_tail = 0;
    if (len_out != 0 && n > len_out) begin
      // Decimation: keep the first sample of largest magnitude in the group.
      if (!holding || mag > best_mag) begin
        best_val = s;
        best_mag = mag[SW:0];
        holding  = 1'b1;
      end
      if (out_idx < len_out && longint'(smp_idx) + 1 == longint'(grp_end)) begin
        out_idx     = out_idx + 1'b1;
        r.value     = best_val;
        r.last      = 1'b1;
        r.frame_end = (out_idx == len_out);
        expected_beats.push_back(r);
        holding  = 1'b0;
        best_mag = '0;
        grp_end  = next_group_end();
      end
    end else if (len_out != 0) begin
      // Copy or repeat: every output position up to ceil((i+1)*out/in).
      upto = ((longint'(smp_idx) + 1) * longint'(len_out) + n - 1) / n;
      if (upto > len_out) upto = len_out;
      total = (upto > out_idx) ? upto - out_idx : 0;
      cnt   = (total > MAX_RESULTS) ? MAX_RESULTS : int'(total);
      drop_tail = total - cnt;
      for (int k = 0; k < cnt; k++) begin
        r.value     = s;
        r.last      = (k == cnt - 1);
        r.frame_end = (k == cnt - 1) && (upto == len_out);
        expected_beats.push_back(r);
      end
      out_idx = LW'(upto);
    end
    if (longint'(smp_idx) + 1 >= n) restart_frame();
    else smp_idx = smp_idx + 1'b1;
  endfunction

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic sample_t pick_sample(sample_t prev);
    case ($urandom_range(0, 9))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2: return -prev;
      3: return prev;
      4: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Input driver: one beat per queued sample, with gaps and drain points.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      src_idle = 0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        resample_sample(sample_if.sample);
        beats_taken++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (src_idle > 0) begin
          src_idle--;
          sample_if.valid <= 1'b0;
        end else if (sample_backlog.size() != 0 &&
                     !(sample_backlog[0].drain && expected_beats.size() != 0)) begin
          sample_if.valid  <= 1'b1;
          sample_if.sample <= sample_backlog[0].sample;
          void'(sample_backlog.pop_front());
          src_idle = pick_gap(src_gaps);
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure and a field-by-field compare.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      sink_idle = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: value %0d", result_if.value);
          mismatches++;
        end else begin
          head = expected_beats.pop_front();
          if (result_if.value !== head.value) begin
            $error("value: expected %0d, got %0d", head.value, result_if.value);
            mismatches++;
          end
          if (result_if.last !== head.last) begin
            $error("last: expected %0b, got %0b", head.last, result_if.last);
            mismatches++;
          end
          if (result_if.frame_end !== head.frame_end) begin
            $error("frame_end: expected %0b, got %0b", head.frame_end, result_if.frame_end);
            mismatches++;
          end
        end
      end
      if (sink_idle > 0) begin
        sink_idle--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        sink_idle = pick_gap(sink_stalls);
      end
    end
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("max_abs_frame_decimator regression: fail");
      $finish;
    end
  end

  task automatic feed(sample_t s, bit drain);
    stim_t st;
    st.sample = s;
    st.drain  = drain;
    sample_backlog.push_back(st);
    beats_queued++;
  endtask

  // Wait until every sample is taken and every result has come, then let the
  // block finish any silent cycles spent on dropped repeats.
  task automatic settle();
    while (beats_taken != beats_queued || expected_beats.size() != 0) @(posedge clk_i);
    repeat (int'(drop_tail) + 8) @(posedge clk_i);
  endtask

  // Register writes go out back to back; any write restarts the frame.
  task automatic set_lengths(bit wr_in, int in_v, bit wr_out, int out_v);
    if (wr_in) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_IN_LEN;
      cfg_data_i <= LW'(in_v);
    end
    if (wr_out) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_OUT_LEN;
      cfg_data_i <= LW'(out_v);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (wr_in) len_in = LW'(in_v);
    if (wr_out) len_out = LW'(out_v);
    restart_frame();
  endtask

  initial begin
    int      mode;
    int      in_v;
    int      out_v;
    int      n;
    int      rand_items;
    sample_t s;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_IN_LEN;
    cfg_data_i       = '0;
    sample_if.valid  = 1'b0;
    sample_if.sample = '0;
    result_if.ready  = 1'b0;
    beats_queued     = 0;
    beats_taken      = 0;
    mismatches       = 0;
    cycle_cnt        = 0;
    src_gaps         = 1'b1;
    sink_stalls      = 1'b1;
    drop_tail        = 0;
    len_in           = LW'(IN_LEN_RESET);
    len_out          = LW'(OUT_LEN_RESET);
    restart_frame();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lengths after reset: groups of four, ties keep the first sample and
    // the most negative code beats the most positive one.
    feed(16'sd100, 1'b0);
    feed(-16'sd100, 1'b0);
    feed(16'sd3, 1'b0);
    feed(-16'sd3, 1'b0);
    feed(SMP_MAX, 1'b0);
    feed(SMP_MIN, 1'b0);
    feed('0, 1'b0);
    feed(-16'sd1, 1'b0);
    settle();

    // Zero input length acts as one sample per frame.
    set_lengths(1'b1, 0, 1'b1, 1);
    feed(16'sd1, 1'b0);
    feed(-16'sd1, 1'b0);
    feed('0, 1'b0);
    settle();

    // No outputs at all.
    set_lengths(1'b1, 3, 1'b1, 0);
    feed(SMP_MAX, 1'b0);
    feed(SMP_MIN, 1'b0);
    settle();

    // Widest repeat ratio: the cap cuts each sample short.
    set_lengths(1'b1, 1, 1'b1, 65535);
    feed(16'sd12345, 1'b0);
    feed(SMP_MIN, 1'b0);
    settle();

    // Longest frame, copied through; only the input length is rewritten.
    set_lengths(1'b1, 65535, 1'b0, 0);
    feed(SMP_MIN, 1'b0);
    feed(SMP_MAX, 1'b0);
    feed(16'sd7, 1'b0);
    settle();

    // Uneven repeat counts over a whole frame.
    set_lengths(1'b1, 5, 1'b1, 12);
    feed(16'sd5, 1'b0);
    feed(-16'sd6, 1'b0);
    feed(SMP_MAX, 1'b0);
    feed(SMP_MIN, 1'b0);
    feed('0, 1'b0);
    settle();

    // Random phases over decimation, copy, repetition and silent settings.
    rand_items = 0;
    s = '0;
    while (rand_items < 330) begin
      mode = $urandom_range(0, 9);
      n    = $urandom_range(15, 50);
      if (mode <= 4) begin
        in_v  = $urandom_range(2, 48);
        out_v = $urandom_range(1, in_v - 1);
      end else if (mode == 5) begin
        in_v  = $urandom_range(1, 32);
        out_v = in_v;
      end else if (mode <= 7) begin
        in_v  = $urandom_range(1, 16);
        out_v = $urandom_range(in_v + 1, in_v * 8);
      end else if (mode == 8) begin
        in_v  = $urandom_range(1, 3);
        out_v = in_v * $urandom_range(60, 90);
        n     = $urandom_range(4, 12);
      end else if ($urandom_range(0, 1) == 1) begin
        in_v  = $urandom_range(0, 10);
        out_v = 0;
      end else begin
        in_v  = 0;
        out_v = $urandom_range(1, 80);
      end
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      set_lengths(1'b1, in_v, 1'b1, out_v);
      for (int k = 0; k < n; k++) begin
        s = pick_sample(s);
        feed(s, (k == n / 2) || ($urandom_range(0, 24) == 0));
      end
      rand_items += n;
      settle();
    end

    if (mismatches == 0) begin
      $display("max_abs_frame_decimator regression: pass");
    end else begin
      $display("max_abs_frame_decimator regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mafd_pkg.sv
hw/rtl/mafd_if.sv
hw/rtl/mafd_core.sv
hw/rtl/max_abs_frame_decimator.sv
hw/rtl/mafd_checker.sv
test/tb_top.sv
